// File: hdl/segx_pkg.sv
package segx_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int T_FRAC_BITS = 32;
   localparam int EPS_WIDTH = 32;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd4295;

   // Status carried from the front end to the divider.
   typedef struct packed {
      logic valid;
      logic hit;
   } segx_ctl_type;

endpackage

// File: hdl/segx_front.sv
// Differences, cross products and the hit test; four register stages.
module segx_front #(
   parameter int CW = segx_pkg::COORD_WIDTH_DEF,
   parameter int PW = 2 * CW + 4
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [CW-1:0] a0x,
   input  logic signed [CW-1:0] a0y,
   input  logic signed [CW-1:0] a1x,
   input  logic signed [CW-1:0] a1y,
   input  logic signed [CW-1:0] b0x,
   input  logic signed [CW-1:0] b0y,
   input  logic signed [CW-1:0] b1x,
   input  logic signed [CW-1:0] b1y,
   input  logic [segx_pkg::EPS_WIDTH-1:0] eps,
   output segx_pkg::segx_ctl_type ctl_out,
   output logic [PW-1:0] num_mag,
   output logic [PW-1:0] den_mag,
   output logic signed [CW-1:0] base_x,
   output logic signed [CW-1:0] base_y,
   output logic signed [CW:0] delta_x,
   output logic signed [CW:0] delta_y
);
   import segx_pkg::*;

   localparam int DW = CW + 1;

   // stage 1: differences
   logic v1_ff;
   logic signed [DW-1:0] adx_ff, ady_ff, bdx_ff, bdy_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [CW-1:0] bx1_ff, by1_ff;
   // stage 2: products
   logic v2_ff;
   logic signed [2*DW-1:0] p_ff [6];
   logic signed [CW-1:0] bx2_ff, by2_ff;
   logic signed [DW-1:0] ex2_ff, ey2_ff;
   // stage 3: sums
   logic v3_ff;
   logic signed [PW-1:0] d_ff, tn_ff, un_ff;
   logic signed [CW-1:0] bx3_ff, by3_ff;
   logic signed [DW-1:0] ex3_ff, ey3_ff;
   // stage 4: test and magnitudes
   segx_ctl_type ctl_ff, ctl_in;
   logic [PW-1:0] nm_ff, dm_ff, nm_in, dm_in;
   logic signed [CW-1:0] bx4_ff, by4_ff;
   logic signed [DW-1:0] ex4_ff, ey4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         ctl_ff <= '0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      adx_ff <= DW'(a0x) - DW'(a1x);
      ady_ff <= DW'(a0y) - DW'(a1y);
      bdx_ff <= DW'(b0x) - DW'(b1x);
      bdy_ff <= DW'(b0y) - DW'(b1y);
      sx_ff <= DW'(a0x) - DW'(b0x);
      sy_ff <= DW'(a0y) - DW'(b0y);
      ex_ff <= DW'(a1x) - DW'(a0x);
      ey_ff <= DW'(a1y) - DW'(a0y);
      bx1_ff <= a0x;
      by1_ff <= a0y;

      p_ff[0] <= adx_ff * bdy_ff;
      p_ff[1] <= ady_ff * bdx_ff;
      p_ff[2] <= sx_ff * bdy_ff;
      p_ff[3] <= sy_ff * bdx_ff;
      p_ff[4] <= sx_ff * ady_ff;
      p_ff[5] <= sy_ff * adx_ff;
      bx2_ff <= bx1_ff;
      by2_ff <= by1_ff;
      ex2_ff <= ex_ff;
      ey2_ff <= ey_ff;

      d_ff <= PW'(p_ff[0]) - PW'(p_ff[1]);
      tn_ff <= PW'(p_ff[2]) - PW'(p_ff[3]);
      un_ff <= PW'(p_ff[4]) - PW'(p_ff[5]);
      bx3_ff <= bx2_ff;
      by3_ff <= by2_ff;
      ex3_ff <= ex2_ff;
      ey3_ff <= ey2_ff;

      nm_ff <= nm_in;
      dm_ff <= dm_in;
      bx4_ff <= bx3_ff;
      by4_ff <= by3_ff;
      ex4_ff <= ex3_ff;
      ey4_ff <= ey3_ff;
   end

   logic [PW-1:0] tm, um;
   logic t_ok, u_ok, d_ok;

   always_comb begin
      dm_in = d_ff[PW-1] ? PW'(-d_ff) : PW'(d_ff);
      tm = tn_ff[PW-1] ? PW'(-tn_ff) : PW'(tn_ff);
      um = un_ff[PW-1] ? PW'(-un_ff) : PW'(un_ff);
      nm_in = tm;
      d_ok = (d_ff != '0) && (dm_in >= PW'(eps));
      t_ok = (tn_ff == '0) || ((tn_ff[PW-1] == d_ff[PW-1]) && (tm <= dm_in));
      u_ok = (un_ff == '0) || ((un_ff[PW-1] == d_ff[PW-1]) && (um <= dm_in));
      ctl_in.valid = v3_ff;
      ctl_in.hit = d_ok && t_ok && u_ok;
   end

   assign ctl_out = ctl_ff;
   assign num_mag = nm_ff;
   assign den_mag = dm_ff;
   assign base_x = bx4_ff;
   assign base_y = by4_ff;
   assign delta_x = ex4_ff;
   assign delta_y = ey4_ff;

   property p_valid_flow;
      @(posedge clock) disable iff (reset) in_valid |=> ##3 ctl_ff.valid;
   endproperty
   a_valid_flow: assert property (p_valid_flow) else $error("front valid lost");

   property p_hit_num;
      @(posedge clock) disable iff (reset) ctl_ff.hit |-> (nm_ff <= dm_ff) && (dm_ff != '0);
   endproperty
   a_hit_num: assert property (p_hit_num) else $error("hit with t outside range");

   property p_eps;
      @(posedge clock) disable iff (reset) ctl_ff.hit |-> dm_ff >= PW'($past(eps));
   endproperty
   a_eps: assert property (p_eps) else $error("hit below epsilon");

endmodule

// File: hdl/segx_div.sv
// Restoring divider, one quotient bit per stage, T_FRAC_BITS+1 stages.
module segx_div #(
   parameter int CW = segx_pkg::COORD_WIDTH_DEF,
   parameter int PW = 2 * CW + 4
) (
   input  logic clock,
   input  logic reset,
   input  segx_pkg::segx_ctl_type ctl_in,
   input  logic [PW-1:0] num_mag,
   input  logic [PW-1:0] den_mag,
   input  logic signed [CW-1:0] base_x_in,
   input  logic signed [CW-1:0] base_y_in,
   input  logic signed [CW:0] delta_x_in,
   input  logic signed [CW:0] delta_y_in,
   output segx_pkg::segx_ctl_type ctl_out,
   output logic [segx_pkg::T_FRAC_BITS:0] quot,
   output logic signed [CW-1:0] base_x,
   output logic signed [CW-1:0] base_y,
   output logic signed [CW:0] delta_x,
   output logic signed [CW:0] delta_y
);
   import segx_pkg::*;

   localparam int NS = T_FRAC_BITS + 1;
   localparam int QW = T_FRAC_BITS + 1;
   localparam int RW = PW + 1;

   segx_ctl_type ctl_ff [NS];
   logic [RW-1:0] rem_ff [NS];
   logic [PW-1:0] den_ff [NS];
   logic [QW-1:0] q_ff [NS];
   logic signed [CW-1:0] bx_ff [NS], by_ff [NS];
   logic signed [CW:0] ex_ff [NS], ey_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) ctl_ff[s] <= '0;
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < NS; s++) ctl_ff[s] <= ctl_ff[s-1];
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [RW-1:0] r_cur, r_in;
      logic [PW-1:0] d_cur;
      logic [QW-1:0] q_cur;
      logic signed [CW-1:0] bx_cur, by_cur;
      logic signed [CW:0] ex_cur, ey_cur;
      logic bit_in;
      if (s == 0) begin : g_first
         assign r_cur = RW'(num_mag);
         assign d_cur = den_mag;
         assign q_cur = '0;
         assign bx_cur = base_x_in;
         assign by_cur = base_y_in;
         assign ex_cur = delta_x_in;
         assign ey_cur = delta_y_in;
      end else begin : g_next
         assign r_cur = {rem_ff[s-1][RW-2:0], 1'b0};
         assign d_cur = den_ff[s-1];
         assign q_cur = q_ff[s-1];
         assign bx_cur = bx_ff[s-1];
         assign by_cur = by_ff[s-1];
         assign ex_cur = ex_ff[s-1];
         assign ey_cur = ey_ff[s-1];
      end
      always_comb begin
         bit_in = r_cur >= RW'(d_cur);
         r_in = bit_in ? r_cur - RW'(d_cur) : r_cur;
      end
      always_ff @(posedge clock) begin
         rem_ff[s] <= r_in;
         den_ff[s] <= d_cur;
         q_ff[s] <= {q_cur[QW-2:0], bit_in};
         bx_ff[s] <= bx_cur;
         by_ff[s] <= by_cur;
         ex_ff[s] <= ex_cur;
         ey_ff[s] <= ey_cur;
      end
   end

   assign ctl_out = ctl_ff[NS-1];
   assign quot = q_ff[NS-1];
   assign base_x = bx_ff[NS-1];
   assign base_y = by_ff[NS-1];
   assign delta_x = ex_ff[NS-1];
   assign delta_y = ey_ff[NS-1];

   property p_q_range;
      @(posedge clock) disable iff (reset)
         ctl_out.valid && ctl_out.hit && quot[QW-1] |-> quot[QW-2:0] == '0;
   endproperty
   a_q_range: assert property (p_q_range) else $error("quotient above one");

   property p_valid_flow;
      @(posedge clock) disable iff (reset) ctl_in.valid |=> ##(NS-1) ctl_out.valid;
   endproperty
   a_valid_flow: assert property (p_valid_flow) else $error("divider valid lost");

   property p_hit_flow;
      @(posedge clock) disable iff (reset)
         ctl_in.valid && ctl_in.hit |=> ##(NS-1) ctl_out.hit;
   endproperty
   a_hit_flow: assert property (p_hit_flow) else $error("divider hit lost");

endmodule

// File: hdl/segx_point.sv
// Interpolation: two multiply stages, then round, add and register the result.
module segx_point #(
   parameter int CW = segx_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  segx_pkg::segx_ctl_type ctl_in,
   input  logic [segx_pkg::T_FRAC_BITS:0] quot,
   input  logic signed [CW-1:0] base_x,
   input  logic signed [CW-1:0] base_y,
   input  logic signed [CW:0] delta_x,
   input  logic signed [CW:0] delta_y,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic signed [CW-1:0] rsp_cross_x,
   output logic signed [CW-1:0] rsp_cross_y
);
   import segx_pkg::*;

   localparam int QW = T_FRAC_BITS + 1;
   localparam int HW = (QW + 1) / 2;
   localparam int MW = QW + CW + 2;

   // stage 1: partial products of low and high halves of t
   segx_ctl_type c1_ff, c2_ff;
   logic signed [HW+CW+1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [CW-1:0] bx1_ff, by1_ff, bx2_ff, by2_ff;
   logic signed [MW-1:0] px_ff, py_ff;
   logic v_ff, h_ff;
   logic signed [CW-1:0] x_ff, y_ff;

   logic signed [HW:0] q_lo, q_hi;
   assign q_lo = $signed({1'b0, HW'(quot)});
   assign q_hi = $signed({1'b0, HW'(quot >> HW)});

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         v_ff <= 1'b0;
      end else begin
         c1_ff <= ctl_in;
         c2_ff <= c1_ff;
         v_ff <= c2_ff.valid;
      end
   end

   logic signed [MW-1:0] rx, ry;
   always_comb begin
      rx = px_ff + MW'(64'sd1 <<< (T_FRAC_BITS - 1));
      ry = py_ff + MW'(64'sd1 <<< (T_FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      lo_x_ff <= q_lo * delta_x;
      lo_y_ff <= q_lo * delta_y;
      hi_x_ff <= q_hi * delta_x;
      hi_y_ff <= q_hi * delta_y;
      bx1_ff <= base_x;
      by1_ff <= base_y;
      px_ff <= (MW'(hi_x_ff) <<< HW) + MW'(lo_x_ff);
      py_ff <= (MW'(hi_y_ff) <<< HW) + MW'(lo_y_ff);
      bx2_ff <= bx1_ff;
      by2_ff <= by1_ff;
      h_ff <= c2_ff.hit;
      x_ff <= c2_ff.hit ? bx2_ff + CW'(rx >>> T_FRAC_BITS) : '0;
      y_ff <= c2_ff.hit ? by2_ff + CW'(ry >>> T_FRAC_BITS) : '0;
   end

   assign rsp_valid = v_ff;
   assign rsp_hit = v_ff & h_ff;
   assign rsp_cross_x = x_ff;
   assign rsp_cross_y = y_ff;

   property p_miss_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_hit |-> rsp_cross_x == '0 && rsp_cross_y == '0;
   endproperty
   a_miss_zero: assert property (p_miss_zero) else $error("miss with nonzero point");

   property p_flow;
      @(posedge clock) disable iff (reset) ctl_in.valid |=> ##2 rsp_valid;
   endproperty
   a_flow: assert property (p_flow) else $error("point stage lost request");

   property p_hit_flow;
      @(posedge clock) disable iff (reset) ctl_in.valid && ctl_in.hit |=> ##2 rsp_hit;
   endproperty
   a_hit_flow: assert property (p_hit_flow) else $error("point stage lost hit");

endmodule

// File: hdl/segment_intersection.sv
// Channel   | ports                                  | handshake
// request   | start, busy, req_* endpoints           | taken when start && !busy
// response  | rsp_valid, rsp_hit, rsp_cross_x/y      | one cycle, cannot be held
// csr       | csr_write, csr_wdata (det_epsilon)     | taken when csr_write
//
// One request enters every cycle; busy stays low. Each response passes
// through the front end, the divider and the point stages, and its delay
// is set mostly by the one-bit-per-stage divider for t.
// Synchronous reset clears all valid bits and loads det_epsilon with 4295.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module segment_intersection #(
   parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_y,
   input  logic csr_write,
   input  logic [segx_pkg::EPS_WIDTH-1:0] csr_wdata,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y
);
   import segx_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 4;

   // Hold the epsilon register; write it only while idle, which the block itself does not enforce.
   logic [EPS_WIDTH-1:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) eps_ff <= EPS_RESET;
      else if (csr_write) eps_ff <= csr_wdata;
   end

   // The pipeline never stalls, so a request is always taken.
   assign busy = 1'b0;

   segx_ctl_type f_ctl, d_ctl;
   logic [PW-1:0] n_mag, d_mag;
   logic signed [COORD_WIDTH-1:0] f_bx, f_by, d_bx, d_by;
   logic signed [COORD_WIDTH:0] f_ex, f_ey, d_ex, d_ey;
   logic [T_FRAC_BITS:0] q;

   // Differences, products and the range test.
   segx_front #(.CW(COORD_WIDTH), .PW(PW)) u_front (
      .clock, .reset,
      .in_valid(start & ~busy),
      .a0x(req_first_start_x), .a0y(req_first_start_y),
      .a1x(req_first_end_x), .a1y(req_first_end_y),
      .b0x(req_second_start_x), .b0y(req_second_start_y),
      .b1x(req_second_end_x), .b1y(req_second_end_y),
      .eps(eps_ff),
      .ctl_out(f_ctl), .num_mag(n_mag), .den_mag(d_mag),
      .base_x(f_bx), .base_y(f_by), .delta_x(f_ex), .delta_y(f_ey)
   );

   // t = |tn| / |d| as unsigned Q1.32.
   segx_div #(.CW(COORD_WIDTH), .PW(PW)) u_div (
      .clock, .reset,
      .ctl_in(f_ctl), .num_mag(n_mag), .den_mag(d_mag),
      .base_x_in(f_bx), .base_y_in(f_by), .delta_x_in(f_ex), .delta_y_in(f_ey),
      .ctl_out(d_ctl), .quot(q),
      .base_x(d_bx), .base_y(d_by), .delta_x(d_ex), .delta_y(d_ey)
   );

   // Point a0 + t*(a1-a0), rounded to nearest; zero on a miss.
   segx_point #(.CW(COORD_WIDTH)) u_point (
      .clock, .reset,
      .ctl_in(d_ctl), .quot(q),
      .base_x(d_bx), .base_y(d_by), .delta_x(d_ex), .delta_y(d_ey),
      .rsp_valid, .rsp_hit, .rsp_cross_x, .rsp_cross_y
   );

   property p_latency;
      @(posedge clock) disable iff (reset) start |=> ##(T_FRAC_BITS + 7) rsp_valid;
   endproperty
   a_latency: assert property (p_latency) else $error("response missing");

   property p_never_busy;
      @(posedge clock) !busy;
   endproperty
   a_never_busy: assert property (p_never_busy) else $error("busy raised");

   property p_eps_write;
      @(posedge clock) disable iff (reset) csr_write |=> eps_ff == $past(csr_wdata);
   endproperty
   a_eps_write: assert property (p_eps_write) else $error("epsilon not written");

endmodule

// File: bench/tb_top.sv
module tb_top;
   import segx_pkg::*;

   localparam int CW        = COORD_WIDTH_DEF;
   localparam int LATENCY   = 40;
   localparam int SETTLE    = LATENCY + 8;
   localparam int CYCLE_CAP = 300000;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [127:0]  wide_type;

   typedef struct {
      logic      hit;
      coord_type cx;
      coord_type cy;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type a0x = '0, a0y = '0, a1x = '0, a1y = '0;
   coord_type b0x = '0, b0y = '0, b1x = '0, b1y = '0;
   logic csr_write = 1'b0;
   logic [EPS_WIDTH-1:0] csr_wdata = '0;
   logic rsp_valid, rsp_hit;
   coord_type rsp_cross_x, rsp_cross_y;

   logic [EPS_WIDTH-1:0] eps_shadow;
   crossing_type pending_crossings[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  allow_gaps = 1'b0;

   segment_intersection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_start_x(a0x), .req_first_start_y(a0y),
      .req_first_end_x(a1x), .req_first_end_y(a1y),
      .req_second_start_x(b0x), .req_second_start_y(b0y),
      .req_second_end_x(b1x), .req_second_end_y(b1y),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Exact integer model of the intersection: determinants in units of 2^-32,
   // t as an unsigned Q1.32 quotient, point rounded to nearest, ties upward.
   function automatic logic unit_range(input wide_type num, input wide_type den);
      wide_type mn, md;
      begin
         mn = (num < 0) ? -num : num;
         md = (den < 0) ? -den : den;
         if (num == 0) return 1'b1;
         if ((num < 0) != (den < 0)) return 1'b0;
         return mn <= md;
      end
   endfunction

   function automatic coord_type lerp_coord(input wide_type base, input wide_type delta,
                                            input wide_type t);
      wide_type p;
      begin
         p = t * delta + (wide_type'(1) <<< (T_FRAC_BITS - 1));
         p = p >>> T_FRAC_BITS;
         return coord_type'(base + p);
      end
   endfunction

   function automatic crossing_type predict_crossing(input logic [EPS_WIDTH-1:0] eps);
      wide_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      wide_type det, tnum, unum, mag_det, mag_t, t;
      crossing_type r;
      begin
         ax0 = a0x; ay0 = a0y; ax1 = a1x; ay1 = a1y;
         bx0 = b0x; by0 = b0y; bx1 = b1x; by1 = b1y;
         det  = (ax0 - ax1) * (by0 - by1) - (ay0 - ay1) * (bx0 - bx1);
         tnum = (ax0 - bx0) * (by0 - by1) - (ay0 - by0) * (bx0 - bx1);
         unum = (ax0 - bx0) * (ay0 - ay1) - (ay0 - by0) * (ax0 - ax1);
         r.hit = 1'b0; r.cx = '0; r.cy = '0;
         mag_det = (det < 0) ? -det : det;
         mag_t   = (tnum < 0) ? -tnum : tnum;
         // a zero determinant never hits, whatever the threshold
         if (det == 0 || mag_det < wide_type'({1'b0, eps})) return r;
         if (!unit_range(tnum, det) || !unit_range(unum, det)) return r;
         t = (mag_t <<< T_FRAC_BITS) / mag_det;
         r.hit = 1'b1;
         r.cx = lerp_coord(ax0, ax1 - ax0, t);
         r.cy = lerp_coord(ay0, ay1 - ay0, t);
         return r;
      end
   endfunction

   // Scoreboard: check the response of this edge first, then log the request
   // taken at the same edge; the register shadow follows each csr write.
   always @(posedge clock) begin
      crossing_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         eps_shadow <= EPS_RESET;
      end else begin
         if (rsp_valid) begin
            if (pending_crossings.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               fail_count++;
            end else begin
               want = pending_crossings.pop_front();
               if (rsp_hit !== want.hit || rsp_cross_x !== want.cx ||
                   rsp_cross_y !== want.cy) begin
                  $display("%0t: mismatch expected hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
                           $time, want.hit, want.cx, want.cy,
                           rsp_hit, rsp_cross_x, rsp_cross_y);
                  fail_count++;
               end
            end
         end
         if (start && !busy) pending_crossings.push_back(predict_crossing(eps_shadow));
         if (csr_write) eps_shadow <= csr_wdata;
      end
   end

   // Hard stop, well beyond the slowest legal run.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one request from the falling edge and hold it until taken.
   task automatic send_request(input coord_type p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y);
      logic was_busy;
      int gap;
      begin
         @(negedge clock);
         if (allow_gaps && $urandom_range(0, 5) == 0) begin
            start = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clock);
         end
         a0x = p0x; a0y = p0y; a1x = p1x; a1y = p1y;
         b0x = q0x; b0y = q0y; b1x = q1x; b1y = q1y;
         start = 1'b1;
         forever begin
            was_busy = busy;
            @(posedge clock);
            if (!was_busy) break;
            @(negedge clock);
         end
      end
   endtask

   // Drop start, wait for every response, then let the pipeline empty.
   task automatic drain_pipeline;
      begin
         @(negedge clock);
         start = 1'b0;
         while (pending_crossings.size() != 0) @(negedge clock);
         repeat (SETTLE) @(negedge clock);
      end
   endtask

   task automatic write_epsilon(input logic [EPS_WIDTH-1:0] value);
      begin
         drain_pipeline();
         csr_wdata = value;
         csr_write = 1'b1;
         @(negedge clock);
         csr_write = 1'b0;
      end
   endtask

   function automatic coord_type q16(input int whole);
      return coord_type'(whole) <<< 16;
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   // Small coordinates make hits likely; some fractional bits keep rounding busy.
   function automatic coord_type near_coord();
      return coord_type'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
   endfunction

   task automatic test_crossing_shapes;
      begin
         // plain X crossing and a miss beside it
         send_request(q16(0), q16(0), q16(2), q16(2), q16(0), q16(2), q16(2), q16(0));
         send_request(q16(0), q16(0), q16(1), q16(1), q16(3), q16(0), q16(4), q16(-1));
         // touches at each end of either segment
         send_request(q16(0), q16(0), q16(4), q16(0), q16(0), q16(-2), q16(0), q16(2));
         send_request(q16(0), q16(0), q16(4), q16(0), q16(4), q16(-2), q16(4), q16(2));
         send_request(q16(0), q16(0), q16(4), q16(0), q16(2), q16(0), q16(2), q16(3));
         send_request(q16(0), q16(0), q16(4), q16(0), q16(2), q16(-3), q16(2), q16(0));
         // parallel, collinear and degenerate segments
         send_request(q16(0), q16(0), q16(4), q16(4), q16(0), q16(1), q16(4), q16(5));
         send_request(q16(0), q16(0), q16(4), q16(4), q16(1), q16(1), q16(6), q16(6));
         send_request(q16(1), q16(1), q16(1), q16(1), q16(0), q16(0), q16(2), q16(2));
         // rounding: crossing at the midpoint, where both coordinates tie
         send_request(q16(0), q16(0), 32'sd1, 32'sd3, 32'sd1, 32'sd0, 32'sd0, 32'sd3);
         // extremes of the coordinate range
         send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
         send_request(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
         send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
         send_request(32'sh80000000, 32'sh00000000, 32'sh7fffffff, 32'sh00000000,
                      32'sh00000000, 32'sh80000000, 32'sh00000000, 32'sh7fffffff);
         send_request(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                      32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
      end
   endtask

   task automatic test_epsilon_threshold;
      begin
         // zero threshold: tiny determinants now count, zero still never does
         write_epsilon('0);
         send_request(32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, 32'sd1, 32'sd1, 32'sd0);
         send_request(q16(0), q16(0), q16(4), q16(4), q16(1), q16(1), q16(6), q16(6));
         // largest threshold: only determinants of at least 2^32-1 (just under one square unit) pass
         write_epsilon('1);
         send_request(32'sd0, 32'sd0, 32'sd65536, 32'sd65536,
                      32'sd0, 32'sd65536, 32'sd65536, 32'sd0);
         send_request(q16(0), q16(0), q16(2), q16(2), q16(0), q16(2), q16(2), q16(0));
         write_epsilon(EPS_RESET);
      end
   endtask

   // Mostly well-formed nearby segments, the rest raw random bits.
   task automatic test_random_pairs(input int count);
      begin
         repeat (count) begin
            if ($urandom_range(0, 3) == 0)
               send_request(any_coord(), any_coord(), any_coord(), any_coord(),
                            any_coord(), any_coord(), any_coord(), any_coord());
            else
               send_request(near_coord(), near_coord(), near_coord(), near_coord(),
                            near_coord(), near_coord(), near_coord(), near_coord());
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_crossing_shapes();
      test_epsilon_threshold();
      allow_gaps = 1'b1;
      test_random_pairs(300);
      write_epsilon($urandom);
      test_random_pairs(250);
      write_epsilon($urandom_range(0, 4096));
      test_random_pairs(250);
      write_epsilon(EPS_RESET);
      // closing stretch at full rate, no gaps
      allow_gaps = 1'b0;
      test_random_pairs(330);
      drain_pipeline();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/segx_pkg.sv
hdl/segx_front.sv
hdl/segx_div.sv
hdl/segx_point.sv
hdl/segment_intersection.sv
bench/tb_top.sv
